FILE: sv/jrkv_pkg.sv
// ----------------------------------------------------------------------------
// jrkv_pkg
// Shared types, constants and helpers of the root-level JSON key/value
// extractor: payload structs, parser state, configuration set.
// ----------------------------------------------------------------------------
package jrkv_pkg;

  localparam int KEY_MAX        = 16;
  localparam int DEPTH_BITS     = 16;
  localparam int TOKEN_BITS     = $clog2(KEY_MAX + 2);
  localparam int CFG_INDEX_BITS = 3;
  localparam int BUF_SIZE_BITS  = 17;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_LOW    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_HIGH   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_LENGTH = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VALUE_MODE = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEFAULT    = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BUF_SIZE   = 3'd5;

  // value modes
  localparam logic [1:0] MODE_INT32  = 2'd0;
  localparam logic [1:0] MODE_INT64  = 2'd1;
  localparam logic [1:0] MODE_STRING = 2'd2;

  // parser phases
  localparam logic [2:0] PH_SCAN      = 3'd0;
  localparam logic [2:0] PH_AFTER_KEY = 3'd1;
  localparam logic [2:0] PH_VALUE     = 3'd2;
  localparam logic [2:0] PH_DIGITS    = 3'd3;
  localparam logic [2:0] PH_STRING    = 3'd4;
  localparam logic [2:0] PH_DONE      = 3'd5;

  // character codes
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_t;

  typedef struct packed {
    logic               has_char;
    logic [7:0]         char_byte;
    logic               is_final;
    logic               found;
    logic signed [63:0] int_value;
  } result_t;

  typedef struct packed {
    logic [63:0]              key_bytes_low;
    logic [63:0]              key_bytes_high;
    logic [4:0]               key_length;
    logic [1:0]               value_mode;
    logic signed [63:0]       default_value;
    logic [BUF_SIZE_BITS-1:0] buf_size;
  } cfg_t;

  typedef struct packed {
    logic [DEPTH_BITS-1:0]    nest_depth;
    logic                     inside_string;
    logic                     escape_pending;
    logic                     string_at_root;
    logic                     key_match_so_far;
    logic [TOKEN_BITS-1:0]    token_length;
    logic [2:0]               phase;
    logic                     minus_seen;
    logic [63:0]              accumulator;
    logic [BUF_SIZE_BITS-1:0] chars_emitted;
  } parse_t;

  function automatic parse_t parse_reset();
    parse_t p;
    p                  = '0;
    p.key_match_so_far = 1'b1;
    p.phase            = PH_SCAN;
    return p;
  endfunction

  function automatic logic [63:0] sext32(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic [63:0] int_result(input logic [63:0] acc, input logic minus,
                                             input logic [1:0] mode);
    logic [63:0] v;
    v = minus ? (64'd0 - acc) : acc;
    return (mode == MODE_INT32) ? sext32(v) : v;
  endfunction

  function automatic logic [63:0] default_result(input logic [63:0] dflt,
                                                 input logic [1:0] mode);
    logic [63:0] r;
    case (mode)
      MODE_STRING: r = 64'd0;
      MODE_INT32:  r = sext32(dflt);
      default:     r = dflt;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/jrkv_step.sv
// ----------------------------------------------------------------------------
// jrkv_step
// One parser step: from the current state, configuration and one text byte,
// forms the next state and at most one result.
// ----------------------------------------------------------------------------
module jrkv_step (
  input  jrkv_pkg::parse_t  state,
  input  jrkv_pkg::cfg_t    cfg,
  input  jrkv_pkg::text_t   item,
  output jrkv_pkg::parse_t  state_next,
  output jrkv_pkg::result_t result,
  output logic              result_valid
);

  localparam logic [jrkv_pkg::DEPTH_BITS-1:0] DEPTH_MAX = '1;
  localparam logic [jrkv_pkg::DEPTH_BITS-1:0] DEPTH_ONE = jrkv_pkg::DEPTH_BITS'(1);
  localparam logic [jrkv_pkg::TOKEN_BITS-1:0] TOKEN_FULL =
    jrkv_pkg::TOKEN_BITS'(jrkv_pkg::KEY_MAX);
  localparam logic [jrkv_pkg::TOKEN_BITS-1:0] TOKEN_OVER =
    jrkv_pkg::TOKEN_BITS'(jrkv_pkg::KEY_MAX + 1);

  logic [7:0]   b;
  logic         last;
  logic         ends;
  logic         is_space;
  logic         is_digit;
  logic [63:0]  digit;
  logic [127:0] key_vec;
  logic [3:0]   key_idx;
  logic [7:0]   key_b;
  logic [jrkv_pkg::TOKEN_BITS-1:0] tok_len;
  logic         tok_match;
  logic [jrkv_pkg::BUF_SIZE_BITS-1:0] chars_inc;
  logic [jrkv_pkg::BUF_SIZE_BITS-1:0] str_limit;
  logic [63:0]  acc_times10;
  jrkv_pkg::parse_t scan;
  jrkv_pkg::parse_t n;
  logic         has_char;
  logic [7:0]   ch;
  logic         fin;
  logic         found;
  logic [63:0]  ival;

  assign b        = item.text_byte;
  assign last     = item.end_of_text;
  assign ends     = (b == jrkv_pkg::CH_NUL) || last;
  assign is_space = (b == jrkv_pkg::CH_SPACE) || (b == jrkv_pkg::CH_TAB) ||
                    (b == jrkv_pkg::CH_LF) || (b == jrkv_pkg::CH_CR);
  assign is_digit = (b >= jrkv_pkg::CH_ZERO) && (b <= jrkv_pkg::CH_NINE);
  assign digit    = {60'd0, 4'(b - jrkv_pkg::CH_ZERO)};

  assign key_vec  = {cfg.key_bytes_high, cfg.key_bytes_low};
  assign key_idx  = 4'(state.token_length);
  assign key_b    = key_vec[{key_idx, 3'b000} +: 8];

  // raw byte of a string token against the key
  always_comb begin
    if (state.token_length < TOKEN_FULL) begin
      tok_len   = state.token_length + 1'b1;
      tok_match = state.key_match_so_far && (key_b == b);
    end else begin
      tok_len   = TOKEN_OVER;
      tok_match = 1'b0;
    end
  end

  assign acc_times10 = {state.accumulator[60:0], 3'b000} + {state.accumulator[62:0], 1'b0};
  assign chars_inc   = state.chars_emitted + 1'b1;
  assign str_limit   = (cfg.buf_size == '0) ? '0 : cfg.buf_size - 1'b1;

  // bracket and string tracking outside a value
  always_comb begin
    scan       = state;
    scan.phase = jrkv_pkg::PH_SCAN;
    if (state.inside_string) begin
      if (state.escape_pending) begin
        scan.escape_pending   = 1'b0;
        scan.token_length     = tok_len;
        scan.key_match_so_far = tok_match;
      end else if (b == jrkv_pkg::CH_BACKSLASH) begin
        scan.escape_pending   = 1'b1;
        scan.token_length     = tok_len;
        scan.key_match_so_far = tok_match;
      end else if (b == jrkv_pkg::CH_QUOTE) begin
        scan.inside_string = 1'b0;
        if (state.string_at_root && state.key_match_so_far &&
            cfg.key_length <= 5'(jrkv_pkg::KEY_MAX) &&
            5'(state.token_length) == cfg.key_length) begin
          scan.phase = jrkv_pkg::PH_AFTER_KEY;
        end
      end else begin
        scan.token_length     = tok_len;
        scan.key_match_so_far = tok_match;
      end
    end else if (b == jrkv_pkg::CH_LBRACE || b == jrkv_pkg::CH_LBRACKET) begin
      if (state.nest_depth != DEPTH_MAX) begin
        scan.nest_depth = state.nest_depth + 1'b1;
      end
    end else if (b == jrkv_pkg::CH_RBRACE || b == jrkv_pkg::CH_RBRACKET) begin
      if (state.nest_depth != '0) begin
        scan.nest_depth = state.nest_depth - 1'b1;
      end
    end else if (b == jrkv_pkg::CH_QUOTE) begin
      scan.inside_string    = 1'b1;
      scan.escape_pending   = 1'b0;
      scan.string_at_root   = (state.nest_depth == DEPTH_ONE);
      scan.key_match_so_far = 1'b1;
      scan.token_length     = '0;
    end
  end

  always_comb begin
    n        = state;
    has_char = 1'b0;
    ch       = 8'd0;
    fin      = 1'b0;
    found    = 1'b0;
    ival     = 64'd0;

    if (state.phase != jrkv_pkg::PH_DONE && b != jrkv_pkg::CH_NUL) begin
      case (state.phase)
        jrkv_pkg::PH_SCAN: begin
          n = scan;
        end
        jrkv_pkg::PH_AFTER_KEY: begin
          if (b == jrkv_pkg::CH_COLON) begin
            n.phase = jrkv_pkg::PH_VALUE;
          end else if (!is_space) begin
            n = scan;
          end
        end
        jrkv_pkg::PH_VALUE: begin
          if (is_space) begin
            n = state;
          end else if (cfg.value_mode == jrkv_pkg::MODE_STRING) begin
            if (b != jrkv_pkg::CH_QUOTE || cfg.buf_size == '0) begin
              fin = 1'b1;
            end else if (cfg.buf_size == jrkv_pkg::BUF_SIZE_BITS'(1)) begin
              fin   = 1'b1;
              found = 1'b1;
            end else begin
              n.phase          = jrkv_pkg::PH_STRING;
              n.escape_pending = 1'b0;
              n.chars_emitted  = '0;
            end
          end else if (b == jrkv_pkg::CH_MINUS) begin
            n.minus_seen = 1'b1;
            n.phase      = jrkv_pkg::PH_DIGITS;
          end else if (is_digit) begin
            n.accumulator = digit;
            n.phase       = jrkv_pkg::PH_DIGITS;
          end else begin
            fin   = 1'b1;
            found = 1'b1;
          end
        end
        jrkv_pkg::PH_DIGITS: begin
          if (is_digit) begin
            n.accumulator = acc_times10 + digit;
          end else begin
            fin   = 1'b1;
            found = 1'b1;
            ival  = jrkv_pkg::int_result(state.accumulator, state.minus_seen,
                                         cfg.value_mode);
          end
        end
        jrkv_pkg::PH_STRING: begin
          if (state.escape_pending) begin
            n.escape_pending = 1'b0;
            has_char         = 1'b1;
            case (b)
              jrkv_pkg::CH_LOWER_N: ch = jrkv_pkg::CH_LF;
              jrkv_pkg::CH_LOWER_T: ch = jrkv_pkg::CH_TAB;
              jrkv_pkg::CH_LOWER_R: ch = jrkv_pkg::CH_CR;
              default:              ch = b;
            endcase
          end else if (b == jrkv_pkg::CH_BACKSLASH) begin
            n.escape_pending = 1'b1;
          end else if (b == jrkv_pkg::CH_QUOTE) begin
            fin   = 1'b1;
            found = 1'b1;
          end else begin
            has_char = 1'b1;
            ch       = b;
          end
          if (has_char) begin
            n.chars_emitted = chars_inc;
            if (chars_inc >= str_limit) begin
              fin   = 1'b1;
              found = 1'b1;
            end
          end
        end
        default: begin
          n = state;
        end
      endcase
      if (fin) begin
        n.phase = jrkv_pkg::PH_DONE;
      end
    end

    // message end closes whatever is still open
    if (n.phase != jrkv_pkg::PH_DONE && ends) begin
      fin = 1'b1;
      case (n.phase)
        jrkv_pkg::PH_SCAN, jrkv_pkg::PH_AFTER_KEY: begin
          found = 1'b0;
          ival  = jrkv_pkg::default_result(cfg.default_value, cfg.value_mode);
        end
        jrkv_pkg::PH_VALUE: begin
          found = (cfg.value_mode != jrkv_pkg::MODE_STRING);
          ival  = 64'd0;
        end
        jrkv_pkg::PH_DIGITS: begin
          found = 1'b1;
          ival  = jrkv_pkg::int_result(n.accumulator, n.minus_seen, cfg.value_mode);
        end
        default: begin
          found = 1'b1;
          ival  = 64'd0;
          // dangling backslash comes out as itself
          if (n.escape_pending && !has_char) begin
            ch       = jrkv_pkg::CH_BACKSLASH;
            has_char = 1'b1;
          end
        end
      endcase
      n.phase = jrkv_pkg::PH_DONE;
    end

    if (ends) begin
      n = jrkv_pkg::parse_reset();
    end
  end

  assign state_next       = n;
  assign result_valid     = has_char || fin;
  assign result.has_char  = has_char;
  assign result.char_byte = has_char ? ch : 8'd0;
  assign result.is_final  = fin;
  assign result.found     = fin && found;
  assign result.int_value = fin ? ival : 64'd0;

endmodule

FILE: sv/json_root_key_value_extractor.sv
// ----------------------------------------------------------------------------
// json_root_key_value_extractor
// Pulls the value of one configured key out of the root object of a JSON
// text that arrives one byte per transaction.
// ----------------------------------------------------------------------------
// Usage
// text channel: one byte per transaction (text_valid, text_stall, text).
//   A zero byte or a byte flagged end_of_text closes the message.
// result channel: results in order (result_valid, result_stall, result).
//   String mode gives one result per decoded character; every message ends
//   with exactly one result that has is_final set.
// cfg channel: cfg_ready is always high; write registers only while idle.
// Pipeline: a byte is taken into the input register; its result, if any, is
//   registered in the output register once that register is free.
// Throughput: one byte per cycle while no result is stalled, set by the single
//   parser step between the input register and the output register.
// Stall: while a result waits, the input register still takes one byte;
//   text_stall rises only when that byte is held behind the stalled result.
// Reset (rst, synchronous): registers return to their reset values, both
//   registers empty, parser at the start of a message.
// ----------------------------------------------------------------------------
module json_root_key_value_extractor (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   text_valid,
  output logic                                   text_stall,
  input  jrkv_pkg::text_t                        text,
  output logic                                   result_valid,
  input  logic                                   result_stall,
  output jrkv_pkg::result_t                      result,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [jrkv_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [63:0]                            cfg_data
);

  jrkv_pkg::cfg_t    cfg;
  jrkv_pkg::parse_t  state;
  jrkv_pkg::parse_t  state_next;
  jrkv_pkg::text_t   item;
  logic              item_valid;
  jrkv_pkg::result_t step_result;
  logic              step_valid;
  logic              advance;
  logic              text_take;

  assign cfg_ready  = 1'b1;
  assign advance    = item_valid && (!result_valid || !result_stall);
  assign text_stall = item_valid && !advance;
  assign text_take  = text_valid && !text_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_bytes_low  <= 64'd0;
      cfg.key_bytes_high <= 64'd0;
      cfg.key_length     <= 5'd0;
      cfg.value_mode     <= jrkv_pkg::MODE_INT32;
      cfg.default_value  <= 64'sd0;
      cfg.buf_size       <= jrkv_pkg::BUF_SIZE_BITS'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        jrkv_pkg::REG_KEY_LOW:    cfg.key_bytes_low  <= cfg_data;
        jrkv_pkg::REG_KEY_HIGH:   cfg.key_bytes_high <= cfg_data;
        jrkv_pkg::REG_KEY_LENGTH: cfg.key_length     <= cfg_data[4:0];
        jrkv_pkg::REG_VALUE_MODE: cfg.value_mode     <= cfg_data[1:0];
        jrkv_pkg::REG_DEFAULT:    cfg.default_value  <= cfg_data;
        jrkv_pkg::REG_BUF_SIZE:   cfg.buf_size       <= cfg_data[jrkv_pkg::BUF_SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (text_take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_take) begin
      item <= text;
    end
  end

  jrkv_step u_step (
    .state        (state),
    .cfg          (cfg),
    .item         (item),
    .state_next   (state_next),
    .result       (step_result),
    .result_valid (step_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jrkv_pkg::parse_reset();
    end else if (advance) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && step_valid) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_valid) begin
      result <= step_result;
    end
  end

endmodule

FILE: sv/jrkv_checker.sv
// ----------------------------------------------------------------------------
// jrkv_checker
// Port-level checks of the key/value extractor, bound to the top level.
// ----------------------------------------------------------------------------
module jrkv_checker (
  input logic              clk,
  input logic              rst,
  input logic              text_stall,
  input logic              result_valid,
  input logic              result_stall,
  input jrkv_pkg::result_t result,
  input logic              cfg_valid,
  input logic              cfg_ready
);

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> result_valid && result_stall)
    else $error("text stalled while result side is free");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !text_stall)
    else $error("pipeline not empty after reset");

  // a character transaction that does not close the message carries no verdict
  a_char_only: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.is_final |->
      result.has_char && !result.found && result.int_value == 64'sd0)
    else $error("non-final result carries a verdict");

  // configuration port never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    $past(cfg_valid) |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind json_root_key_value_extractor jrkv_checker u_jrkv_checker (
  .clk          (clk),
  .rst          (rst),
  .text_stall   (text_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);

FILE: sim/json_root_key_value_extractor_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_root_key_value_extractor_checker
// Watches the text, result and register channels of the key/value extractor.
// Keeps its own parser state and register set, works out the results of each
// accepted text byte and compares every result transaction, field by field,
// with the oldest expected one.
// ----------------------------------------------------------------------------
module json_root_key_value_extractor_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                text_valid,
  input  logic                                text_stall,
  input  jrkv_pkg::text_t                     text,
  input  logic                                result_valid,
  input  logic                                result_stall,
  input  jrkv_pkg::result_t                   result,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [jrkv_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [63:0]                         cfg_data,
  output int                                  results_owed,
  output int                                  mismatch_count
);

  // register set
  logic [63:0]                        key_low, key_high, dflt;
  logic [4:0]                         key_len;
  logic [1:0]                         mode;
  logic [jrkv_pkg::BUF_SIZE_BITS-1:0] buf_size;

  // parser state
  logic [jrkv_pkg::DEPTH_BITS-1:0]    depth;
  logic                               in_string, escaped, string_at_root, key_still_matches;
  int                                 token_len;
  logic [2:0]                         phase;
  logic                               negative;
  logic [63:0]                        accum;
  logic [jrkv_pkg::BUF_SIZE_BITS-1:0] emitted;

  jrkv_pkg::result_t expected_results[$];
  jrkv_pkg::result_t want;
  int                fail_count = 0;

  function automatic void clear_message();
    depth             = '0;
    in_string         = 1'b0;
    escaped           = 1'b0;
    string_at_root    = 1'b0;
    key_still_matches = 1'b1;
    token_len         = 0;
    phase             = jrkv_pkg::PH_SCAN;
    negative          = 1'b0;
    accum             = '0;
    emitted           = '0;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == jrkv_pkg::CH_SPACE || b == jrkv_pkg::CH_TAB ||
           b == jrkv_pkg::CH_LF || b == jrkv_pkg::CH_CR;
  endfunction

  function automatic logic [7:0] key_byte(input int i);
    logic [63:0] w;
    w = (i < 8) ? key_low : key_high;
    return w[(i % 8) * 8 +: 8];
  endfunction

  function automatic logic [63:0] number_value();
    logic [63:0] v;
    v = negative ? -accum : accum;
    if (mode == jrkv_pkg::MODE_INT32) v = 64'($signed(v[31:0]));
    return v;
  endfunction

  function automatic logic [63:0] default_for_mode();
    logic [63:0] v;
    v = dflt;
    if (mode == jrkv_pkg::MODE_STRING) v = '0;
    else if (mode == jrkv_pkg::MODE_INT32) v = 64'($signed(dflt[31:0]));
    return v;
  endfunction

  // raw key comparison, escapes included as they stand in the text
  function automatic void take_token_byte(input logic [7:0] b);
    if (token_len < jrkv_pkg::KEY_MAX) begin
      if (key_byte(token_len) != b) key_still_matches = 1'b0;
      token_len++;
    end else begin
      token_len         = jrkv_pkg::KEY_MAX + 1;
      key_still_matches = 1'b0;
    end
  endfunction

  function automatic void scan_text(input logic [7:0] b);
    if (in_string) begin
      if (escaped) begin
        escaped = 1'b0;
        take_token_byte(b);
      end else if (b == jrkv_pkg::CH_BACKSLASH) begin
        escaped = 1'b1;
        take_token_byte(b);
      end else if (b == jrkv_pkg::CH_QUOTE) begin
        in_string = 1'b0;
        if (string_at_root && key_still_matches && key_len <= jrkv_pkg::KEY_MAX &&
            token_len == key_len)
          phase = jrkv_pkg::PH_AFTER_KEY;
      end else begin
        take_token_byte(b);
      end
    end else if (b == jrkv_pkg::CH_LBRACE || b == jrkv_pkg::CH_LBRACKET) begin
      if (depth != '1) depth++;
    end else if (b == jrkv_pkg::CH_RBRACE || b == jrkv_pkg::CH_RBRACKET) begin
      if (depth != '0) depth--;
    end else if (b == jrkv_pkg::CH_QUOTE) begin
      in_string         = 1'b1;
      escaped           = 1'b0;
      string_at_root    = (depth == 1);
      key_still_matches = 1'b1;
      token_len         = 0;
    end
  endfunction

  function automatic void predict_byte(input jrkv_pkg::text_t t);
    logic [7:0]                         b, ch;
    logic                               last, has, fin, fnd;
    logic [63:0]                        ival;
    logic [jrkv_pkg::BUF_SIZE_BITS-1:0] limit;
    jrkv_pkg::result_t                  r;
    b     = t.text_byte;
    last  = t.end_of_text;
    has   = 1'b0;
    fin   = 1'b0;
    fnd   = 1'b0;
    ch    = '0;
    ival  = '0;
    limit = (buf_size == 0) ? '0 : buf_size - 1'b1;

    if (phase != jrkv_pkg::PH_DONE && b != jrkv_pkg::CH_NUL) begin
      case (phase)
        jrkv_pkg::PH_AFTER_KEY: begin
          if (b == jrkv_pkg::CH_COLON) begin
            phase = jrkv_pkg::PH_VALUE;
          end else if (!is_blank(b)) begin
            phase = jrkv_pkg::PH_SCAN;
            scan_text(b);
          end
        end
        jrkv_pkg::PH_SCAN: scan_text(b);
        jrkv_pkg::PH_VALUE: begin
          if (!is_blank(b)) begin
            if (mode == jrkv_pkg::MODE_STRING) begin
              if (b != jrkv_pkg::CH_QUOTE || buf_size == 0) begin
                fin = 1'b1;
              end else if (buf_size == 1) begin
                fin = 1'b1;
                fnd = 1'b1;
              end else begin
                phase   = jrkv_pkg::PH_STRING;
                escaped = 1'b0;
                emitted = '0;
              end
            end else if (b == jrkv_pkg::CH_MINUS) begin
              negative = 1'b1;
              phase    = jrkv_pkg::PH_DIGITS;
            end else if (b >= jrkv_pkg::CH_ZERO && b <= jrkv_pkg::CH_NINE) begin
              accum = 64'(b - jrkv_pkg::CH_ZERO);
              phase = jrkv_pkg::PH_DIGITS;
            end else begin
              fin = 1'b1;
              fnd = 1'b1;
            end
          end
        end
        jrkv_pkg::PH_DIGITS: begin
          if (b >= jrkv_pkg::CH_ZERO && b <= jrkv_pkg::CH_NINE) begin
            accum = accum * 64'd10 + 64'(b - jrkv_pkg::CH_ZERO);
          end else begin
            fin  = 1'b1;
            fnd  = 1'b1;
            ival = number_value();
          end
        end
        jrkv_pkg::PH_STRING: begin
          if (escaped) begin
            escaped = 1'b0;
            has     = 1'b1;
            case (b)
              jrkv_pkg::CH_LOWER_N: ch = jrkv_pkg::CH_LF;
              jrkv_pkg::CH_LOWER_T: ch = jrkv_pkg::CH_TAB;
              jrkv_pkg::CH_LOWER_R: ch = jrkv_pkg::CH_CR;
              default:              ch = b;
            endcase
          end else if (b == jrkv_pkg::CH_BACKSLASH) begin
            escaped = 1'b1;
          end else if (b == jrkv_pkg::CH_QUOTE) begin
            fin = 1'b1;
            fnd = 1'b1;
          end else begin
            ch  = b;
            has = 1'b1;
          end
          if (has) begin
            emitted = emitted + 1'b1;
            if (emitted >= limit) begin
              fin = 1'b1;
              fnd = 1'b1;
            end
          end
        end
        default: ;
      endcase
      if (fin) phase = jrkv_pkg::PH_DONE;
    end

    // message end closes whatever is still open
    if (phase != jrkv_pkg::PH_DONE && (b == jrkv_pkg::CH_NUL || last)) begin
      fin = 1'b1;
      case (phase)
        jrkv_pkg::PH_SCAN, jrkv_pkg::PH_AFTER_KEY: begin
          fnd  = 1'b0;
          ival = default_for_mode();
        end
        jrkv_pkg::PH_VALUE: begin
          fnd  = (mode != jrkv_pkg::MODE_STRING);
          ival = '0;
        end
        jrkv_pkg::PH_DIGITS: begin
          fnd  = 1'b1;
          ival = number_value();
        end
        default: begin
          fnd  = 1'b1;
          ival = '0;
          if (escaped && !has) begin
            ch  = jrkv_pkg::CH_BACKSLASH;
            has = 1'b1;
          end
        end
      endcase
      phase = jrkv_pkg::PH_DONE;
    end

    if (b == jrkv_pkg::CH_NUL || last) clear_message();

    if (has || fin) begin
      r.has_char  = has;
      r.char_byte = has ? ch : 8'd0;
      r.is_final  = fin;
      r.found     = fin && fnd;
      r.int_value = fin ? ival : 64'd0;
      expected_results.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      key_low  = '0;
      key_high = '0;
      key_len  = '0;
      mode     = jrkv_pkg::MODE_INT32;
      dflt     = '0;
      buf_size = 17'd256;
      clear_message();
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          jrkv_pkg::REG_KEY_LOW:    key_low  = cfg_data;
          jrkv_pkg::REG_KEY_HIGH:   key_high = cfg_data;
          jrkv_pkg::REG_KEY_LENGTH: key_len  = cfg_data[4:0];
          jrkv_pkg::REG_VALUE_MODE: mode     = cfg_data[1:0];
          jrkv_pkg::REG_DEFAULT:    dflt     = cfg_data;
          jrkv_pkg::REG_BUF_SIZE:   buf_size = cfg_data[jrkv_pkg::BUF_SIZE_BITS-1:0];
          default: ;
        endcase
      end
      if (text_valid && !text_stall) predict_byte(text);
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected: %p", result);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (result.has_char !== want.has_char) begin
            $error("has_char: expected %0d, actual %0d", want.has_char, result.has_char);
            fail_count++;
          end
          if (result.char_byte !== want.char_byte) begin
            $error("char_byte: expected %0h, actual %0h", want.char_byte, result.char_byte);
            fail_count++;
          end
          if (result.is_final !== want.is_final) begin
            $error("is_final: expected %0d, actual %0d", want.is_final, result.is_final);
            fail_count++;
          end
          if (result.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, result.found);
            fail_count++;
          end
          if (result.int_value !== want.int_value) begin
            $error("int_value: expected %0d, actual %0d", want.int_value, result.int_value);
            fail_count++;
          end
        end
      end
    end
    results_owed   <= expected_results.size();
    mismatch_count <= fail_count;
  end

endmodule

FILE: sim/json_root_key_value_extractor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_root_key_value_extractor_test
// Feeds the extractor directed JSON messages for each value mode and corner
// case, then random well-formed, broken and noise messages under random
// register settings, with random gaps and result back-pressure. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module json_root_key_value_extractor_test;

  localparam int IDLE_LIMIT    = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TEXT_BYTES    = 1100;
  localparam int CALM_BYTES    = 1000;

  logic                                clk, rst;
  logic                                text_valid, text_stall;
  jrkv_pkg::text_t                     text;
  logic                                result_valid, result_stall;
  jrkv_pkg::result_t                   result;
  logic                                cfg_valid, cfg_ready;
  logic [jrkv_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [63:0]                         cfg_data;
  int                                  results_owed, mismatch_count;

  logic [7:0] msg_bytes[$];
  logic [7:0] key_chars[16];
  int         key_len = 0;
  logic [1:0] cur_mode = jrkv_pkg::MODE_INT32;
  int         bytes_sent = 0;
  int         gap_odds = 0;
  int         stall_odds = 0;
  int         idle_cycles = 0;
  bit         calm = 1'b0;

  json_root_key_value_extractor DUT (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text         (text),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  json_root_key_value_extractor_checker extract_check (
    .clk            (clk),
    .rst            (rst),
    .text_valid     (text_valid),
    .text_stall     (text_stall),
    .text           (text),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .results_owed   (results_owed),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result back-pressure in bursts
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (text_valid && !text_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("json_root_key_value_extractor_test NOT OK");
      $finish;
    end
  end

  // ---------------- message building ----------------

  function automatic void put(input string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
  endfunction

  function automatic void put_blank();
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0:       msg_bytes.push_back(jrkv_pkg::CH_SPACE);
        1:       msg_bytes.push_back(jrkv_pkg::CH_TAB);
        2:       msg_bytes.push_back(jrkv_pkg::CH_LF);
        default: msg_bytes.push_back(jrkv_pkg::CH_CR);
      endcase
    end
  endfunction

  function automatic void put_number();
    int n;
    if ($urandom_range(0, 2) == 0) msg_bytes.push_back(jrkv_pkg::CH_MINUS);
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 22) : $urandom_range(0, 4);
    repeat (n) msg_bytes.push_back(8'(jrkv_pkg::CH_ZERO + $urandom_range(0, 9)));
  endfunction

  function automatic void put_string_body();
    repeat ($urandom_range(0, 10)) begin
      case ($urandom_range(0, 5))
        0: begin
          msg_bytes.push_back(jrkv_pkg::CH_BACKSLASH);
          case ($urandom_range(0, 5))
            0:       msg_bytes.push_back(jrkv_pkg::CH_LOWER_N);
            1:       msg_bytes.push_back(jrkv_pkg::CH_LOWER_T);
            2:       msg_bytes.push_back(jrkv_pkg::CH_LOWER_R);
            3:       msg_bytes.push_back(jrkv_pkg::CH_QUOTE);
            4:       msg_bytes.push_back(jrkv_pkg::CH_BACKSLASH);
            default: msg_bytes.push_back(8'($urandom_range(1, 255)));
          endcase
        end
        1:       msg_bytes.push_back(8'($urandom_range(128, 255)));
        default: msg_bytes.push_back(8'($urandom_range(35, 91)));
      endcase
    end
  endfunction

  function automatic void put_key_name();
    int n;
    n = (key_len > 16) ? 16 : key_len;
    for (int i = 0; i < n; i++) msg_bytes.push_back(key_chars[i]);
    if (n > 0 && $urandom_range(0, 7) == 0) void'(msg_bytes.pop_back());
    else if (key_len > 16 || $urandom_range(0, 7) == 0)
      msg_bytes.push_back(8'($urandom_range(97, 122)));
  endfunction

  function automatic void put_value(input int level);
    case ($urandom_range(0, (level < 3) ? 5 : 3))
      0, 1: put_number();
      2: begin
        put("\"");
        put_string_body();
        put("\"");
      end
      3: put($urandom_range(0, 1) ? "true" : "null");
      4: begin
        put("{");
        put_member(level + 1, $urandom_range(0, 2) == 0);
        put("}");
      end
      default: begin
        put("[");
        put_value(level + 1);
        put(",");
        put_value(level + 1);
        put("]");
      end
    endcase
  endfunction

  function automatic void put_member(input int level, input bit target);
    put_blank();
    put("\"");
    if (target) put_key_name();
    else put_string_body();
    put("\"");
    put_blank();
    put(":");
    put_blank();
    if (target && $urandom_range(0, 1) == 1) begin
      if (cur_mode == jrkv_pkg::MODE_STRING) begin
        put("\"");
        put_string_body();
        put("\"");
      end else begin
        put_number();
      end
    end else begin
      put_value(level);
    end
  endfunction

  function automatic void build_message();
    int m, pos, keep;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 25)) msg_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      put_blank();
      put("{");
      m   = $urandom_range(0, 3);
      pos = $urandom_range(0, m);
      for (int i = 0; i <= m; i++) begin
        if (i != 0) put(",");
        put_member(1, i == pos && $urandom_range(0, 5) != 0);
      end
      put_blank();
      put("}");
      if ($urandom_range(0, 3) == 0) put_value(3);
      // broken message: cut at a random point
      if ($urandom_range(0, 4) == 0) begin
        keep = $urandom_range(1, msg_bytes.size());
        while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
      end
    end
  endfunction

  function automatic void set_key(input string s);
    key_len = s.len();
    foreach (key_chars[i]) key_chars[i] = (i < s.len()) ? s[i] : 8'($urandom);
  endfunction

  function automatic void random_key();
    key_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
    foreach (key_chars[i])
      key_chars[i] = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                                 : 8'($urandom_range(97, 122));
  endfunction

  function automatic int pick_odds();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 2;
      2:       return 5;
      default: return 12;
    endcase
  endfunction

  // ---------------- channel drivers ----------------

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      text_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    text_valid <= 1'b1;
    text       <= {b, last};
    @(posedge clk);
    while (text_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // ending: 0 last byte flagged, 1 closing zero byte, 2 closing zero byte flagged
  task automatic send_message(input int ending);
    int n;
    n = msg_bytes.size();
    for (int i = 0; i < n; i++) send_byte(msg_bytes[i], ending == 0 && i == n - 1);
    if (ending != 0 || n == 0) send_byte(jrkv_pkg::CH_NUL, ending == 2);
    msg_bytes.delete();
  endtask

  task automatic send_text(input string s, input int ending);
    put(s);
    send_message(ending);
  endtask

  // wait for every result, then let bytes with no result leave the pipeline
  task automatic drain();
    text_valid <= 1'b0;
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [jrkv_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] mode, input logic [63:0] dflt,
                           input logic [jrkv_pkg::BUF_SIZE_BITS-1:0] bsize);
    logic [63:0] low_word, high_word, len_word;
    drain();
    for (int i = 0; i < 8; i++) begin
      low_word[i*8 +: 8]  = key_chars[i];
      high_word[i*8 +: 8] = key_chars[i+8];
    end
    len_word      = {$urandom, $urandom};
    len_word[4:0] = 5'(key_len);
    cur_mode      = mode;
    write_reg(jrkv_pkg::REG_KEY_LOW, low_word);
    write_reg(jrkv_pkg::REG_KEY_HIGH, high_word);
    write_reg(jrkv_pkg::REG_KEY_LENGTH, len_word);
    write_reg(jrkv_pkg::REG_VALUE_MODE, {62'd0, mode});
    write_reg(jrkv_pkg::REG_DEFAULT, dflt);
    write_reg(jrkv_pkg::REG_BUF_SIZE, 64'(bsize));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [jrkv_pkg::BUF_SIZE_BITS-1:0] random_buf_size();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return jrkv_pkg::BUF_SIZE_BITS'($urandom_range(0, 8));
      6, 7:             return 17'd256;
      8:                return 17'd65536;
      default:          return '1;
    endcase
  endfunction

  // ---------------- stimulus ----------------

  initial begin
    int msg_count;
    rst        <= 1'b1;
    text_valid <= 1'b0;
    text       <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // int32: sign, wrap, default low word, missing colon, nesting, escapes
    gap_odds   = 4;
    stall_odds = 4;
    set_key("id");
    configure(jrkv_pkg::MODE_INT32, 64'h0000_0001_8000_0005, 17'd256);
    send_text("{\"id\": -123}", 0);
    send_text("{\"id\":4294967297}", 1);
    send_text(" {\"x\":1, \"idd\":2}", 2);
    send_text("{\"id\":", 1);
    send_text("{\"id\":-}", 0);
    send_text("{\"id\" 5}", 0);
    send_text("{\"a\":{\"id\":7},\"b\":[{\"id\":8}]}", 0);
    send_text("{\"id\":\t\015\n 99", 2);
    send_text("{\"i\\d\":1}", 0);
    send_text("{\"id\":true}", 0);
    send_text("\"id\":5", 0);
    send_text("]]}{\"id\":3}", 0);
    send_text("", 1);

    // int64 with the longest key, a longer token, wrap-around
    set_key("abcdefghijklmnop");
    configure(jrkv_pkg::MODE_INT64, 64'h7FFF_FFFF_FFFF_FFFF, 17'd256);
    send_text("{\"abcdefghijklmnop\":-9223372036854775808}", 0);
    send_text("{\"abcdefghijklmnopq\":1}", 0);
    send_text("{\"abcdefghijklmnop\":99999999999999999999}", 1);
    send_text("{\"abcdefghijklmnop\"", 0);
    configure(2'd3, 64'h8000_0000_0000_0000, 17'd256);
    send_text("{\"abcdefghijklmnop\":-42}", 0);
    send_text("{\"zz\":1}", 0);

    // string values: escapes, bytes after the final result, open string
    set_key("");
    configure(jrkv_pkg::MODE_STRING, 64'h0, 17'd256);
    send_text("{\"\":\"a\\n\\t\\r\\q\\\"b\"} \"junk\"", 0);
    send_text("{\"\":5}", 0);
    send_text("{\"\":\"abc", 0);
    send_text("{\"\":\"x\\", 0);
    send_text("{\"\":\"x", 1);

    // buffer bounds
    set_key("k");
    configure(jrkv_pkg::MODE_STRING, 64'h0, 17'd0);
    send_text("{\"k\":\"hello\"}", 0);
    configure(jrkv_pkg::MODE_STRING, 64'h0, 17'd1);
    send_text("{\"k\":\"hello\"}", 0);
    configure(jrkv_pkg::MODE_STRING, 64'h0, 17'd3);
    send_text("{\"k\":\"hello\"}", 0);
    configure(jrkv_pkg::MODE_STRING, 64'h0, 17'd65536);
    send_text("{\"k\":\"hi\"}", 0);

    // key length beyond the key store never matches
    set_key("id");
    key_len = 20;
    configure(jrkv_pkg::MODE_INT64, 64'h1234_5678_9ABC_DEF0, 17'd256);
    send_text("{\"id\":1}", 0);

    // random messages under random settings
    msg_count = 0;
    while (bytes_sent < TEXT_BYTES) begin
      if (msg_count % 12 == 0) begin
        random_key();
        configure(2'($urandom_range(0, 3)), {$urandom, $urandom}, random_buf_size());
      end else if ($urandom_range(0, 25) == 0) begin
        drain();
      end
      calm       = (bytes_sent >= CALM_BYTES);
      gap_odds   = pick_odds();
      stall_odds = pick_odds();
      build_message();
      send_message($urandom_range(0, 2));
      msg_count++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("json_root_key_value_extractor_test OK");
    else
      $display("json_root_key_value_extractor_test NOT OK");
    $finish;
  end

endmodule

FILE: files.f
sv/jrkv_pkg.sv
sv/jrkv_step.sv
sv/json_root_key_value_extractor.sv
sv/jrkv_checker.sv
sim/json_root_key_value_extractor_checker.sv
sim/json_root_key_value_extractor_test.sv
